### sv/slu_pkg.sv
package slu_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BODY = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_NUM  = 2'd3
    } mode_t;

    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_CLOSED  = 3'd1;
    localparam logic [2:0] KIND_EOT     = 3'd2;
    localparam logic [2:0] KIND_NEWLINE = 3'd3;
    localparam logic [2:0] KIND_NOT_LIT = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_7      = "7";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_LC_A   = "a";
    localparam logic [7:0] CH_LC_B   = "b";
    localparam logic [7:0] CH_LC_E   = "e";
    localparam logic [7:0] CH_LC_F   = "f";
    localparam logic [7:0] CH_LC_N   = "n";
    localparam logic [7:0] CH_LC_R   = "r";
    localparam logic [7:0] CH_LC_T   = "t";
    localparam logic [7:0] CH_LC_U   = "u";
    localparam logic [7:0] CH_LC_V   = "v";
    localparam logic [7:0] CH_LC_X   = "x";
    localparam logic [7:0] CH_UC_A   = "A";
    localparam logic [7:0] CH_UC_F   = "F";
    localparam logic [7:0] CH_UC_U   = "U";

    localparam logic [31:0] CP_MAX         = 32'h0010_FFFF;
    localparam logic [20:0] CP_REPLACEMENT = 21'h00_FFFD;

    // one queued job: optional code point (len 0 = none), then optional tail beat
    typedef struct packed {
        logic [2:0]  cp_len;
        logic [20:0] cp;
        logic        tail_valid;
        logic [2:0]  tail_kind;
        logic [7:0]  tail_byte;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
        mode_t      mode;
    } body_t;

    function automatic body_t body_step(input logic [7:0] b, input logic quote_single);
        body_t r;
        logic [7:0] q;
        q = quote_single ? CH_SQUOTE : CH_DQUOTE;
        r.valid = 1'b1;
        r.kind  = KIND_DATA;
        r.data  = 8'h00;
        r.mode  = MODE_IDLE;
        if (b == q) begin
            r.kind = KIND_CLOSED;
        end else if (b == CH_LF || b == CH_CR) begin
            r.kind = KIND_NEWLINE;
        end else if (b == CH_NUL) begin
            r.kind = KIND_EOT;
        end else if (b == CH_BSLASH) begin
            r.valid = 1'b0;
            r.mode  = MODE_ESC;
        end else begin
            r.data = b;
            r.mode = MODE_BODY;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] r;
        case (len)
            3'd1: r = {1'b0, cp[6:0]};
            3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

### sv/slu_front.sv
module slu_front
    import slu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       queue_full,
    output logic       push,
    output job_t       job
);

    mode_t       mode_reg, mode_next;
    logic        quote_single_reg, quote_single_next;
    logic [31:0] esc_value_reg, esc_value_next;
    logic [3:0]  digit_count_reg, digit_count_next;
    logic [3:0]  digit_limit_reg, digit_limit_next;
    logic        esc_hex_reg, esc_hex_next;

    logic        accept;
    logic        is_quote;
    logic        d_valid;
    logic [3:0]  d_val;
    logic [31:0] acc_value;
    logic [3:0]  count_inc;
    logic        num_done;
    logic [31:0] cp_src;
    logic [20:0] cp_clamped;
    logic [2:0]  cp_len;
    body_t       bs;

    assign text_ready = !queue_full;
    assign accept     = text_valid && text_ready;
    assign is_quote   = (text_byte == CH_SQUOTE) || (text_byte == CH_DQUOTE);
    assign bs         = body_step(text_byte, quote_single_reg);

    always_comb
    begin
        d_valid = 1'b1;
        d_val   = 4'd0;
        if (text_byte >= CH_0 && text_byte <= CH_7) begin
            d_val = text_byte[3:0];
        end else if (esc_hex_reg && text_byte > CH_7 && text_byte <= CH_9) begin
            d_val = text_byte[3:0];
        end else if (esc_hex_reg && text_byte >= CH_LC_A && text_byte <= CH_LC_F) begin
            d_val = 4'(text_byte - CH_LC_A + 8'd10);
        end else if (esc_hex_reg && text_byte >= CH_UC_A && text_byte <= CH_UC_F) begin
            d_val = 4'(text_byte - CH_UC_A + 8'd10);
        end else begin
            d_valid = 1'b0;
        end
    end

    assign acc_value = esc_hex_reg ? {esc_value_reg[27:0], d_val}
                                   : {esc_value_reg[28:0], d_val[2:0]};
    assign count_inc = digit_count_reg + 4'd1;
    assign num_done  = count_inc >= digit_limit_reg;
    assign cp_src    = d_valid ? acc_value : esc_value_reg;

    always_comb
    begin
        if (cp_src > CP_MAX) begin
            cp_clamped = CP_REPLACEMENT;
        end else begin
            cp_clamped = cp_src[20:0];
        end
        if (cp_clamped < 21'h80) begin
            cp_len = 3'd1;
        end else if (cp_clamped < 21'h800) begin
            cp_len = 3'd2;
        end else if (cp_clamped < 21'h10000) begin
            cp_len = 3'd3;
        end else begin
            cp_len = 3'd4;
        end
    end

    // next state
    always_comb
    begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        esc_value_next    = esc_value_reg;
        digit_count_next  = digit_count_reg;
        digit_limit_next  = digit_limit_reg;
        esc_hex_next      = esc_hex_reg;
        if (accept) begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (is_quote) begin
                        quote_single_next = (text_byte == CH_SQUOTE);
                        mode_next         = MODE_BODY;
                    end
                end
                MODE_BODY:
                begin
                    mode_next = bs.mode;
                end
                MODE_ESC:
                begin
                    mode_next = MODE_BODY;
                    if (text_byte == CH_NUL) begin
                        mode_next = MODE_IDLE;
                    end else if (text_byte == CH_LC_X || text_byte == CH_LC_U
                                 || text_byte == CH_UC_U) begin
                        mode_next        = MODE_NUM;
                        esc_value_next   = 32'd0;
                        digit_count_next = 4'd0;
                        esc_hex_next     = 1'b1;
                        if (text_byte == CH_LC_X) begin
                            digit_limit_next = 4'd2;
                        end else if (text_byte == CH_LC_U) begin
                            digit_limit_next = 4'd4;
                        end else begin
                            digit_limit_next = 4'd8;
                        end
                    end else if (text_byte >= CH_0 && text_byte <= CH_7) begin
                        mode_next        = MODE_NUM;
                        esc_value_next   = {29'd0, text_byte[2:0]};
                        digit_count_next = 4'd1;
                        digit_limit_next = 4'd3;
                        esc_hex_next     = 1'b0;
                    end
                end
                default:
                begin
                    if (!d_valid) begin
                        mode_next = bs.mode;
                    end else begin
                        esc_value_next   = acc_value;
                        digit_count_next = count_inc;
                        if (num_done) begin
                            mode_next = MODE_BODY;
                        end
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        job        = '0;
        push       = 1'b0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (!is_quote) begin
                    job.tail_valid = 1'b1;
                    job.tail_kind  = KIND_NOT_LIT;
                end
            end
            MODE_BODY:
            begin
                job.tail_valid = bs.valid;
                job.tail_kind  = bs.kind;
                job.tail_byte  = bs.data;
            end
            MODE_ESC:
            begin
                job.tail_valid = 1'b1;
                job.tail_kind  = KIND_DATA;
                case (text_byte)
                    CH_NUL:   job.tail_kind = KIND_EOT;
                    CH_LC_N:  job.tail_byte = CH_LF;
                    CH_LC_A:  job.tail_byte = CH_BEL;
                    CH_LC_E:  job.tail_byte = CH_ESC;
                    CH_LC_R:  job.tail_byte = CH_CR;
                    CH_LC_T:  job.tail_byte = CH_TAB;
                    CH_LC_B:  job.tail_byte = CH_BS;
                    CH_LC_F:  job.tail_byte = CH_FF;
                    CH_LC_V:  job.tail_byte = CH_VT;
                    CH_LC_X,
                    CH_LC_U,
                    CH_UC_U:  job.tail_valid = 1'b0;
                    default:
                    begin
                        if (text_byte >= CH_0 && text_byte <= CH_7) begin
                            job.tail_valid = 1'b0;
                        end else begin
                            job.tail_byte = text_byte;
                        end
                    end
                endcase
            end
            default:
            begin
                if (!d_valid) begin
                    job.cp_len     = cp_len;
                    job.cp         = cp_clamped;
                    job.tail_valid = bs.valid;
                    job.tail_kind  = bs.kind;
                    job.tail_byte  = bs.data;
                end else if (num_done) begin
                    job.cp_len = cp_len;
                    job.cp     = cp_clamped;
                end
            end
        endcase
        push = accept && (job.tail_valid || (job.cp_len != 3'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            esc_value_reg    <= 32'd0;
            digit_count_reg  <= 4'd0;
            digit_limit_reg  <= 4'd0;
            esc_hex_reg      <= 1'b0;
        end else begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            esc_value_reg    <= esc_value_next;
            digit_count_reg  <= digit_count_next;
            digit_limit_reg  <= digit_limit_next;
            esc_hex_reg      <= esc_hex_next;
        end
    end

endmodule

### sv/slu_queue.sv
module slu_queue
    import slu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    job_t            entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CntFull);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/slu_back.sv
module slu_back
    import slu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_empty,
    input  job_t       head_job,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    logic       load_out;
    logic       step;
    logic [2:0] n_beats;
    logic       is_last;

    assign load_out = !valid_reg || result_ready;
    assign step     = !queue_empty && load_out;
    assign n_beats  = head_job.cp_len + {2'b00, head_job.tail_valid};
    assign is_last  = (3'(idx_reg + 3'd1) == n_beats);
    assign pop      = step && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load_out) begin
            valid_next = !queue_empty;
        end
        if (step) begin
            last_next = is_last;
            idx_next  = is_last ? 3'd0 : 3'(idx_reg + 3'd1);
            if (idx_reg < head_job.cp_len) begin
                kind_next = KIND_DATA;
                byte_next = utf8_byte(head_job.cp, head_job.cp_len, idx_reg[1:0]);
            end else begin
                kind_next = head_job.tail_kind;
                byte_next = head_job.tail_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign result_valid = valid_reg;
    assign out_kind     = kind_reg;
    assign out_byte     = byte_reg;
    assign last_of_run  = last_reg;

endmodule

### sv/string_literal_unescaper.sv
// Decodes quoted string literals from a byte stream (0 ends the text), resolving
// simple, octal and x/u/U hex escapes into UTF-8 content beats plus status beats
// (closed, end of text, newline error, not a literal); last_of_run marks the final
// beat of each source byte. The front end takes one byte per cycle while the job
// queue has room; the back end sends one result beat per cycle while result_ready
// is high; a byte yields up to five beats when a numeric escape ends. QUEUE_DEPTH
// jobs of slack sit between the two, so short bursts of escape output do not
// stall input.
module string_literal_unescaper
    import slu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    slu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    slu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    slu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import slu_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TOTAL_BYTES   = 360;
    localparam int QUIET_TAIL    = 60;
    localparam int LONG_STALL_AT = 120;
    localparam int LONG_STALL    = 400;
    localparam int DRAIN_AT      = 250;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } beat_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       text_valid   = 1'b0;
    logic [7:0] text_byte    = 8'h00;
    logic       result_ready = 1'b0;
    logic       text_ready;
    logic       result_valid;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    logic       text_fire = 1'b0;

    logic [7:0] pending_bytes[$];
    beat_t      expected_beats[$];
    beat_t      run_beats[$];

    // decoder state
    mode_t       dec_mode         = MODE_IDLE;
    logic        dec_quote_single = 1'b0;
    logic [31:0] dec_value        = 32'd0;
    logic [3:0]  dec_count        = 4'd0;
    logic [3:0]  dec_limit        = 4'd0;
    logic        dec_hex          = 1'b0;

    int mismatches    = 0;
    int bytes_taken   = 0;
    int bytes_sent    = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int cycle_count   = 0;
    bit long_done     = 1'b0;
    bit drain_done    = 1'b0;

    string_literal_unescaper i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic put_beat(input logic [2:0] kind, input logic [7:0] data);
        beat_t b;
        b.kind = kind;
        b.data = data;
        b.last = 1'b0;
        if (run_beats.size() < 5)
            run_beats.push_back(b);
    endtask

    task automatic put_utf8(input logic [31:0] cp);
        logic [31:0] c;
        c = (cp > CP_MAX) ? {11'd0, CP_REPLACEMENT} : cp;
        if (c < 32'h80)
        begin
            put_beat(KIND_DATA, c[7:0]);
        end
        else if (c < 32'h800)
        begin
            put_beat(KIND_DATA, {3'b110, c[10:6]});
            put_beat(KIND_DATA, {2'b10, c[5:0]});
        end
        else if (c < 32'h10000)
        begin
            put_beat(KIND_DATA, {4'b1110, c[15:12]});
            put_beat(KIND_DATA, {2'b10, c[11:6]});
            put_beat(KIND_DATA, {2'b10, c[5:0]});
        end
        else
        begin
            put_beat(KIND_DATA, {5'b11110, c[20:18]});
            put_beat(KIND_DATA, {2'b10, c[17:12]});
            put_beat(KIND_DATA, {2'b10, c[11:6]});
            put_beat(KIND_DATA, {2'b10, c[5:0]});
        end
    endtask

    function automatic int digit_val(input logic [7:0] b, input logic hex);
        if (b >= CH_0 && b <= CH_7)
            return int'(b - CH_0);
        if (!hex)
            return -1;
        if (b >= CH_0 && b <= CH_9)
            return int'(b - CH_0);
        if (b >= CH_LC_A && b <= CH_LC_F)
            return int'(b - CH_LC_A) + 10;
        if (b >= CH_UC_A && b <= CH_UC_F)
            return int'(b - CH_UC_A) + 10;
        return -1;
    endfunction

    task automatic body_char(input logic [7:0] b);
        logic [7:0] q;
        q = dec_quote_single ? CH_SQUOTE : CH_DQUOTE;
        if (b == q)
        begin
            put_beat(KIND_CLOSED, 8'h00);
            dec_mode = MODE_IDLE;
        end
        else if (b == CH_LF || b == CH_CR)
        begin
            put_beat(KIND_NEWLINE, 8'h00);
            dec_mode = MODE_IDLE;
        end
        else if (b == CH_NUL)
        begin
            put_beat(KIND_EOT, 8'h00);
            dec_mode = MODE_IDLE;
        end
        else if (b == CH_BSLASH)
        begin
            dec_mode = MODE_ESC;
        end
        else
        begin
            put_beat(KIND_DATA, b);
        end
    endtask

    task automatic start_number(input logic [31:0] v, input logic [3:0] cnt,
                                input logic [3:0] lim, input logic hex);
        dec_value = v;
        dec_count = cnt;
        dec_limit = lim;
        dec_hex   = hex;
        dec_mode  = MODE_NUM;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int d;
        beat_t t;
        run_beats.delete();
        case (dec_mode)
            MODE_IDLE:
            begin
                if (b == CH_SQUOTE || b == CH_DQUOTE)
                begin
                    dec_quote_single = (b == CH_SQUOTE);
                    dec_mode = MODE_BODY;
                end
                else
                begin
                    put_beat(KIND_NOT_LIT, 8'h00);
                end
            end
            MODE_BODY:
            begin
                body_char(b);
            end
            MODE_ESC:
            begin
                dec_mode = MODE_BODY;
                case (b)
                    CH_NUL:
                    begin
                        put_beat(KIND_EOT, 8'h00);
                        dec_mode = MODE_IDLE;
                    end
                    CH_LC_N: put_beat(KIND_DATA, CH_LF);
                    CH_LC_A: put_beat(KIND_DATA, CH_BEL);
                    CH_LC_E: put_beat(KIND_DATA, CH_ESC);
                    CH_LC_R: put_beat(KIND_DATA, CH_CR);
                    CH_LC_T: put_beat(KIND_DATA, CH_TAB);
                    CH_LC_B: put_beat(KIND_DATA, CH_BS);
                    CH_LC_F: put_beat(KIND_DATA, CH_FF);
                    CH_LC_V: put_beat(KIND_DATA, CH_VT);
                    CH_LC_X: start_number(32'd0, 4'd0, 4'd2, 1'b1);
                    CH_LC_U: start_number(32'd0, 4'd0, 4'd4, 1'b1);
                    CH_UC_U: start_number(32'd0, 4'd0, 4'd8, 1'b1);
                    default:
                    begin
                        if (b >= CH_0 && b <= CH_7)
                            start_number({24'd0, b - CH_0}, 4'd1, 4'd3, 1'b0);
                        else
                            put_beat(KIND_DATA, b);
                    end
                endcase
            end
            default:
            begin
                d = digit_val(b, dec_hex);
                if (d < 0)
                begin
                    put_utf8(dec_value);
                    dec_mode = MODE_BODY;
                    body_char(b);
                end
                else
                begin
                    dec_value = dec_value * (dec_hex ? 32'd16 : 32'd8) + 32'(d);
                    dec_count = dec_count + 4'd1;
                    if (dec_count >= dec_limit)
                    begin
                        put_utf8(dec_value);
                        dec_mode = MODE_BODY;
                    end
                end
            end
        endcase
        if (run_beats.size() > 0)
            run_beats[run_beats.size() - 1].last = 1'b1;
        while (run_beats.size() > 0)
        begin
            t = run_beats.pop_front();
            expected_beats.push_back(t);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
        end
        else if (text_valid && !text_fire)
        begin
            text_valid <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left = gap_left - 1;
            text_valid <= 1'b0;
        end
        else if (!drain_done && bytes_sent == DRAIN_AT)
        begin
            if (expected_beats.size() == 0)
                drain_done = 1'b1;
            text_valid <= 1'b0;
        end
        else if (pending_bytes.size() > 0)
        begin
            text_valid <= 1'b1;
            text_byte  <= pending_bytes.pop_front();
            bytes_sent = bytes_sent + 1;
            if (pending_bytes.size() > QUIET_TAIL && (bytes_sent / 64) % 3 != 2
                && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 14);
        end
        else
        begin
            text_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (!long_done && bytes_taken >= LONG_STALL_AT)
        begin
            long_done = 1'b1;
            stall_left = LONG_STALL - 1;
            result_ready <= 1'b0;
        end
        else if (pending_bytes.size() > QUIET_TAIL && (bytes_taken / 50) % 3 != 1
                 && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        beat_t e;
        text_fire <= rst_n && text_valid && text_ready;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected beat: kind=%0d byte=%02h last=%0b",
                                 out_kind, out_byte, last_of_run);
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (out_kind !== e.kind || out_byte !== e.data || last_of_run !== e.last)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("beat mismatch: exp kind=%0d byte=%02h last=%0b, %s",
                                     e.kind, e.data, e.last,
                                     $sformatf("got kind=%0d byte=%02h last=%0b",
                                               out_kind, out_byte, last_of_run));
                    end
                end
            end
            if (text_valid && text_ready)
            begin
                decode_byte(text_byte);
                bytes_taken = bytes_taken + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int unsigned sel;
        int unsigned n;
        int unsigned ndig;
        int unsigned lim;
        int unsigned v;
        bit low_plane;
        logic [7:0] q;
        logic [7:0] b;
        string simple_esc;

        simple_esc = "naertbfv\\'\"?";

        // idle bytes, hex, octal overflow past a byte, surrogate, empty hex,
        // unknown letter, raw CR escape, newline error, end of text after backslash
        pending_bytes = '{8'h00, 8'hFF, CH_DQUOTE,
                          CH_BSLASH, CH_LC_X, CH_LC_F, CH_UC_F,
                          CH_BSLASH, CH_7, CH_7, CH_7,
                          CH_BSLASH, CH_LC_U, "d", "8", CH_0, CH_0,
                          CH_BSLASH, CH_LC_X, "g",
                          CH_BSLASH, "q",
                          CH_BSLASH, CH_CR,
                          CH_SQUOTE, CH_LF,
                          CH_SQUOTE, CH_BSLASH, CH_NUL};

        while (pending_bytes.size() < TOTAL_BYTES)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                pending_bytes.push_back(q);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 4)
                    begin
                        b = 8'($urandom_range(1, 255));
                        if (b == q || b == CH_BSLASH || b == CH_CR || b == CH_LF)
                            b = "z";
                        pending_bytes.push_back(b);
                    end
                    else if (sel == 4)
                    begin
                        pending_bytes.push_back(CH_BSLASH);
                        pending_bytes.push_back(
                            simple_esc[$urandom_range(0, simple_esc.len() - 1)]);
                    end
                    else if (sel == 5)
                    begin
                        pending_bytes.push_back(CH_BSLASH);
                        pending_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                    else if (sel == 6)
                    begin
                        pending_bytes.push_back(CH_BSLASH);
                        ndig = $urandom_range(1, 3);
                        repeat (ndig)
                            pending_bytes.push_back(8'(CH_0 + $urandom_range(0, 7)));
                    end
                    else
                    begin
                        pending_bytes.push_back(CH_BSLASH);
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                pending_bytes.push_back(CH_LC_X);
                                lim = 2;
                            end
                            1:
                            begin
                                pending_bytes.push_back(CH_LC_U);
                                lim = 4;
                            end
                            default:
                            begin
                                pending_bytes.push_back(CH_UC_U);
                                lim = 8;
                            end
                        endcase
                        ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim) : lim;
                        low_plane = $urandom_range(0, 1);
                        for (int i = 0; i < ndig; i++)
                        begin
                            v = $urandom_range(0, 15);
                            if (lim == 8 && low_plane && i < 2)
                                v = 0;
                            if (lim == 8 && low_plane && i == 2)
                                v = $urandom_range(0, 1);
                            if (v < 10)
                                b = 8'(CH_0 + v);
                            else if ($urandom_range(0, 1))
                                b = 8'(CH_LC_A + v - 10);
                            else
                                b = 8'(CH_UC_A + v - 10);
                            pending_bytes.push_back(b);
                        end
                    end
                end
                sel = $urandom_range(0, 99);
                if (sel < 80)
                begin
                    pending_bytes.push_back(q);
                end
                else if (sel < 87)
                begin
                    pending_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                end
                else if (sel < 94)
                begin
                    pending_bytes.push_back(CH_NUL);
                end
                else
                begin
                    pending_bytes.push_back(CH_BSLASH);
                    pending_bytes.push_back(CH_NUL);
                end
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || text_valid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
